[design/rthsv_pkg.sv]
package rthsv_pkg;

    localparam int CH_W    = 8;
    localparam int NUM_W   = 2 * CH_W;
    localparam int HNUM_W  = NUM_W + 2;

    // hue scale factors in two-degree units
    localparam int HUE_K   = 30;
    localparam int HUE_GRN = 60;
    localparam int HUE_BLU = 120;
    localparam int HUE_WRP = 180;
    localparam int SAT_K   = 255;

    // radix-2 steps done in one divider stage
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = CH_W / DIV_STEPS_PER_STAGE;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [NUM_W-1:0] t_divw;

    // one restoring step: upper half holds the partial remainder,
    // lower half shifts numerator bits out and quotient bits in
    function automatic t_divw div_step(input t_divw w, input t_chan dv);
        logic [CH_W:0] t;
        logic [CH_W:0] dx;
        t_divw         res;
        t  = {w[NUM_W-1:CH_W], w[CH_W-1]};
        dx = {1'b0, dv};
        if (t >= dx) begin
            res = {CH_W'(t - dx), w[CH_W-2:0], 1'b1};
        end else begin
            res = {t[CH_W-1:0], w[CH_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[design/rthsv_if.sv]
interface rthsv_in_if;
    import rthsv_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsv_out_if;
    import rthsv_pkg::*;

    logic  valid;
    logic  ready;
    t_chan hue;
    t_chan saturation;
    t_chan brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

[design/rgb_to_hsv_pixel.sv]
// six register stages; the last of them is the output register
// throughput: one pixel per clock while the output is ready; the two dividers are split over four
//   stages of two restoring steps each, so every stage takes a new pixel
// a stalled output holds the pipeline back stage by stage, bubbles fill in
// reset (synchronous, active low) clears the stage valid bits only
module rgb_to_hsv_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rthsv_in_if.sink    i_pix,
    rthsv_out_if.source o_hsv
);
    import rthsv_pkg::*;

    localparam int NSTG = 2 + DIV_STAGES;

    // which channel holds the maximum
    localparam logic [1:0] SEL_RED = 2'd0;
    localparam logic [1:0] SEL_GRN = 2'd1;
    localparam logic [1:0] SEL_BLU = 2'd2;

    // stage valid bits and per-stage advance enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_en;

    always_comb begin
        w_en[NSTG] = o_hsv.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: max, min, spread and the channel difference for hue
    // ---------------------------------------------------------------
    t_chan              n1_mx;
    t_chan              n1_mn;
    logic [1:0]         n1_sel;
    logic signed [CH_W:0] n1_diff;

    t_chan              r1_mx;
    t_chan              r1_d;
    logic [1:0]         r1_sel;
    logic signed [CH_W:0] r1_diff;

    always_comb begin
        n1_mx = i_pix.red;
        if (i_pix.green > n1_mx) n1_mx = i_pix.green;
        if (i_pix.blue  > n1_mx) n1_mx = i_pix.blue;
        n1_mn = i_pix.red;
        if (i_pix.green < n1_mn) n1_mn = i_pix.green;
        if (i_pix.blue  < n1_mn) n1_mn = i_pix.blue;

        // ties go red first, then green
        if (n1_mx == i_pix.red) begin
            n1_sel  = SEL_RED;
            n1_diff = signed'({1'b0, i_pix.green}) - signed'({1'b0, i_pix.blue});
        end else if (n1_mx == i_pix.green) begin
            n1_sel  = SEL_GRN;
            n1_diff = signed'({1'b0, i_pix.blue}) - signed'({1'b0, i_pix.red});
        end else begin
            n1_sel  = SEL_BLU;
            n1_diff = signed'({1'b0, i_pix.red}) - signed'({1'b0, i_pix.green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_mx   <= n1_mx;
            r1_d    <= n1_mx - n1_mn;
            r1_sel  <= n1_sel;
            r1_diff <= n1_diff;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: numerators and divisors of both quotients
    // ---------------------------------------------------------------
    logic signed [HNUM_W-1:0] n2_dext;
    logic signed [HNUM_W-1:0] n2_off;
    logic signed [HNUM_W-1:0] n2_hsum;
    logic signed [HNUM_W-1:0] n2_hnum;

    t_divw r2_hnum;
    t_divw r2_snum;
    t_chan r2_hdiv;
    t_chan r2_sdiv;
    t_chan r2_mx;

    always_comb begin
        n2_dext = signed'({{(HNUM_W-CH_W){1'b0}}, r1_d});
        case (r1_sel)
            SEL_RED: n2_off = '0;
            SEL_GRN: n2_off = n2_dext * HNUM_W'(HUE_GRN);
            SEL_BLU: n2_off = n2_dext * HNUM_W'(HUE_BLU);
            default: n2_off = '0;
        endcase
        n2_hsum = HNUM_W'(r1_diff) * HNUM_W'(HUE_K) + n2_off;
        // negative hue wraps by a full turn
        if (n2_hsum < 0) begin
            n2_hnum = n2_hsum + n2_dext * HNUM_W'(HUE_WRP);
        end else begin
            n2_hnum = n2_hsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_hnum <= NUM_W'(n2_hnum);
            r2_snum <= NUM_W'({{CH_W{1'b0}}, r1_d} * NUM_W'(SAT_K));
            // grey and black give a zero numerator, divide by one then
            r2_hdiv <= (r1_d  == '0) ? CH_W'(1) : r1_d;
            r2_sdiv <= (r1_mx == '0) ? CH_W'(1) : r1_mx;
            r2_mx   <= r1_mx;
        end
    end

    // ---------------------------------------------------------------
    // stages 3..6: two restoring divider steps per stage for each
    // quotient; both quotients are known to fit in one byte
    // ---------------------------------------------------------------
    t_divw r_hw  [DIV_STAGES];
    t_divw r_sw  [DIV_STAGES];
    t_chan r_hdv [DIV_STAGES];
    t_chan r_sdv [DIV_STAGES];
    t_chan r_mx  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        t_divw w_hin;
        t_divw w_sin;
        t_chan w_hdv;
        t_chan w_sdv;
        t_chan w_mx;
        t_divw w_hout;
        t_divw w_sout;

        if (s == 0) begin : g_first
            assign w_hin = r2_hnum;
            assign w_sin = r2_snum;
            assign w_hdv = r2_hdiv;
            assign w_sdv = r2_sdiv;
            assign w_mx  = r2_mx;
        end else begin : g_next
            assign w_hin = r_hw[s-1];
            assign w_sin = r_sw[s-1];
            assign w_hdv = r_hdv[s-1];
            assign w_sdv = r_sdv[s-1];
            assign w_mx  = r_mx[s-1];
        end

        always_comb begin
            w_hout = w_hin;
            w_sout = w_sin;
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                w_hout = div_step(w_hout, w_hdv);
                w_sout = div_step(w_sout, w_sdv);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s+2]) begin
                r_hw[s]  <= w_hout;
                r_sw[s]  <= w_sout;
                r_hdv[s] <= w_hdv;
                r_sdv[s] <= w_sdv;
                r_mx[s]  <= w_mx;
            end
        end
    end

    // last stage is the output register
    assign o_hsv.valid      = r_vld[NSTG-1];
    assign o_hsv.hue        = r_hw[DIV_STAGES-1][CH_W-1:0];
    assign o_hsv.saturation = r_sw[DIV_STAGES-1][CH_W-1:0];
    assign o_hsv.brightness = r_mx[DIV_STAGES-1];

endmodule
